>>> src/dns_name_decompressor_macros.svh
// ---------------------------------------------------------------------------
// DNS name decompressor assertion macros
// Concurrent check wrappers; define NO_ASSERTIONS to compile them out.
// ---------------------------------------------------------------------------
`ifndef DNS_NAME_DECOMPRESSOR_MACROS_SVH
`define DNS_NAME_DECOMPRESSOR_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define DND_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dns_name_decompressor: same-cycle check failed");

// next-cycle implication
`define DND_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dns_name_decompressor: next-cycle check failed");

`else

`define DND_ASSERT_SAME(label, clk, rst, ante, cons)
`define DND_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

>>> src/dnd_pkg.sv
// ---------------------------------------------------------------------------
// DNS name decompressor package
// Shared types, codes and fixed sizes of the name decompressor.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dnd_pkg;

   // walk position: wide enough for a 14-bit pointer and the largest store
   localparam int POS_W = 17;

   localparam int          HOPS_W     = 4;
   localparam logic [3:0]  HOPS_RESET = 4'd8;

   localparam logic [7:0]  CHAR_DOT   = 8'h2E;

   // label type in the top two bits of a label head
   localparam logic [1:0]  LBL_PLAIN   = 2'b00;
   localparam logic [1:0]  LBL_POINTER = 2'b11;

   // command queue between front and back
   localparam int QUEUE_DEPTH = 4;

   // name buffer: four byte lanes, one group of four characters per row
   localparam int LANES     = 4;
   localparam int GRP_DEPTH = 64;
   localparam int GRP_W     = 6;
   localparam int TEXT_W    = 8;

   typedef enum logic [2:0] {
      ERR_NONE     = 3'd0,
      ERR_PAST_END = 3'd1,
      ERR_RESERVED = 3'd2,
      ERR_HOPS     = 3'd3,
      ERR_TOO_LONG = 3'd4
   } err_type;

   typedef enum logic {
      OP_WRITE  = 1'b0,
      OP_DECODE = 1'b1
   } opcode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_HEAD,
      ST_PTR,
      ST_LABEL,
      ST_ERROR,
      ST_EMIT
   } state_type;

   // classified request handed from front to back
   typedef struct packed {
      logic             decode;
      logic             in_range;
      logic [8:0]       offset;
      logic [7:0]       data;
      logic [POS_W-1:0] limit;
   } cmd_type;

endpackage

`default_nettype wire

>>> src/dnd_channels.sv
// ---------------------------------------------------------------------------
// DNS name decompressor channels
// Valid/ready interfaces for the request and response streams.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface dnd_req_if;
   logic       valid;
   logic       ready;
   logic       opcode;
   logic [8:0] byte_offset;
   logic [7:0] data_byte;
   logic [9:0] message_length;

   modport source (output valid, output opcode, output byte_offset,
                   output data_byte, output message_length, input ready);
   modport sink   (input valid, input opcode, input byte_offset,
                   input data_byte, input message_length, output ready);
endinterface

interface dnd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_0;
   logic [7:0] char_1;
   logic [7:0] char_2;
   logic [7:0] char_3;
   logic [2:0] char_count;
   logic       last_group;
   logic [8:0] wire_length;
   logic [2:0] error_code;

   modport source (output valid, output char_0, output char_1, output char_2,
                   output char_3, output char_count, output last_group,
                   output wire_length, output error_code, input ready);
   modport sink   (input valid, input char_0, input char_1, input char_2,
                   input char_3, input char_count, input last_group,
                   input wire_length, input error_code, output ready);
endinterface

`default_nettype wire

>>> src/dnd_front.sv
// ---------------------------------------------------------------------------
// DNS name decompressor front end
// Accepts requests, classifies them and queues them for the engine.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dnd_front import dnd_pkg::*; #(
   parameter int MSG_BYTES = 512
) (
   input  logic    clock,
   input  logic    reset,
   dnd_req_if.sink req_bus,
   output logic    cmd_valid,
   output cmd_type cmd,
   input  logic    cmd_pop
);

   localparam int QW = $clog2(QUEUE_DEPTH);
   localparam logic [POS_W-1:0] STORE_SIZE = POS_W'(MSG_BYTES);
   localparam logic [QW:0]      FULL_COUNT = (QW+1)'(QUEUE_DEPTH);

   cmd_type          queue_ff [QUEUE_DEPTH];
   logic [QW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [QW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QW:0]      count_ff, count_in;
   logic             push;
   logic             pop;
   cmd_type          new_cmd;
   logic [POS_W-1:0] mlen_ext;

   // classify: decode or write, clip the valid length to the store size
   assign mlen_ext         = POS_W'(req_bus.message_length);
   assign new_cmd.decode   = (req_bus.opcode == OP_DECODE);
   assign new_cmd.in_range = (POS_W'(req_bus.byte_offset) < STORE_SIZE);
   assign new_cmd.offset   = req_bus.byte_offset;
   assign new_cmd.data     = req_bus.data_byte;
   assign new_cmd.limit    = (mlen_ext < STORE_SIZE) ? mlen_ext : STORE_SIZE;

   // queue handshake
   assign req_bus.ready = (count_ff != FULL_COUNT);
   assign push          = req_bus.valid & req_bus.ready;
   assign cmd_valid     = (count_ff != '0);
   assign pop           = cmd_pop & cmd_valid;
   assign cmd           = queue_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= new_cmd;
      end
   end

endmodule

`default_nettype wire

>>> src/dnd_engine.sv
// ---------------------------------------------------------------------------
// DNS name decompressor engine
// Message store, label walker, name buffer and response output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dnd_engine import dnd_pkg::*; #(
   parameter int MSG_BYTES = 512,
   parameter int MAX_NAME  = 255
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [HOPS_W-1:0] max_hops,
   input  logic              cmd_valid,
   input  cmd_type           cmd,
   output logic              cmd_pop,
   dnd_rsp_if.source         rsp_bus
);

   localparam int AW = (MSG_BYTES > 1) ? $clog2(MSG_BYTES) : 1;

   // message store and name buffer
   logic [7:0] msg_mem  [MSG_BYTES];
   logic [7:0] name_buf [LANES][GRP_DEPTH];

   state_type         state_ff, state_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [8:0]        start_ff, start_in;
   logic [POS_W-1:0]  limit_ff, limit_in;
   logic [HOPS_W-1:0] hop_ff, hop_in;
   logic              jumped_ff, jumped_in;
   logic [8:0]        wire_ff, wire_in;
   logic [7:0]        name_len_ff, name_len_in;
   logic [TEXT_W-1:0] text_len_ff, text_len_in;
   logic [5:0]        remain_ff, remain_in;
   logic [5:0]        ptr_hi_ff, ptr_hi_in;
   err_type           err_ff, err_in;
   logic [GRP_W-1:0]  grp_ff, grp_in;

   // store ports
   logic              mem_wr;
   logic              rd_en;
   logic [POS_W-1:0]  rd_pos;
   logic [7:0]        rd_data_ff;
   logic              buf_wr;
   logic [7:0]        buf_wdata;
   logic              buf_rd;
   logic [7:0]        grp_data_ff [LANES];

   // group read stage
   logic              dv_ff, dv_in;
   logic [2:0]        cnt_pipe_ff;
   logic              last_pipe_ff;
   logic [8:0]        wire_pipe_ff;

   // output register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        rsp_char_ff [LANES];
   logic [2:0]        rsp_cnt_ff;
   logic              rsp_last_ff;
   logic [8:0]        rsp_wire_ff;
   err_type           rsp_err_ff;

   // walk conditions
   logic [POS_W-1:0]  pos_next;
   logic              past_next;
   logic              start_past;
   logic              is_zero, is_ptr, is_plain;
   logic              hop_full;
   logic              long_name;
   logic [POS_W-1:0]  ptr_target;
   logic              ptr_past;
   logic [POS_W-1:0]  span;
   logic              out_can_load;
   logic              can_issue;
   logic              load_grp, load_err;
   logic [GRP_W-1:0]  last_grp;
   logic [8:0]        grp_rem;
   logic [2:0]        grp_cnt;
   logic [TEXT_W-1:0] text_dec;

   assign pos_next   = pos_ff + 1'b1;
   assign past_next  = (pos_next >= limit_ff);
   assign start_past = (POS_W'(cmd.offset) >= cmd.limit);
   assign is_zero    = (rd_data_ff == 8'd0);
   assign is_ptr     = (rd_data_ff[7:6] == LBL_POINTER);
   assign is_plain   = (rd_data_ff[7:6] == LBL_PLAIN);
   assign hop_full   = (hop_ff >= max_hops);
   assign long_name  = ((10'(name_len_ff) + 10'(rd_data_ff) + 10'd2) > 10'(MAX_NAME));
   assign ptr_target = POS_W'({ptr_hi_ff, rd_data_ff});
   assign ptr_past   = (ptr_target >= limit_ff);
   assign span       = pos_ff - POS_W'(start_ff);

   // output slot frees when empty or taken this cycle
   assign out_can_load = !rsp_valid_ff || rsp_bus.ready;
   assign can_issue    = !dv_ff || out_can_load;
   assign load_grp     = dv_ff && out_can_load;
   assign load_err     = (state_ff == ST_ERROR) && !dv_ff && out_can_load;

   // group bookkeeping: index of the last group and characters in this one
   assign text_dec = text_len_ff - 1'b1;
   assign last_grp = (text_len_ff == '0) ? '0 : text_dec[TEXT_W-1:2];
   assign grp_rem  = 9'(text_len_ff) - 9'({grp_ff, 2'b00});
   assign grp_cnt  = (grp_rem > 9'd4) ? 3'd4 : grp_rem[2:0];

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid && cmd.decode) begin
               state_in = start_past ? ST_ERROR : ST_HEAD;
            end
         end
         ST_HEAD: begin
            if (is_zero) begin
               state_in = ST_EMIT;
            end else if (is_ptr) begin
               state_in = (past_next || hop_full) ? ST_ERROR : ST_PTR;
            end else if (!is_plain) begin
               state_in = ST_ERROR;
            end else begin
               state_in = (long_name || past_next) ? ST_ERROR : ST_LABEL;
            end
         end
         ST_PTR: begin
            state_in = ptr_past ? ST_ERROR : ST_HEAD;
         end
         ST_LABEL: begin
            if (past_next) begin
               state_in = ST_ERROR;
            end else if (remain_ff == 6'd1) begin
               state_in = ST_HEAD;
            end
         end
         ST_ERROR: begin
            if (!dv_ff && out_can_load) begin
               state_in = ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (can_issue && grp_ff == last_grp) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // walker datapath and store controls
   always_comb begin
      pos_in      = pos_ff;
      start_in    = start_ff;
      limit_in    = limit_ff;
      hop_in      = hop_ff;
      jumped_in   = jumped_ff;
      wire_in     = wire_ff;
      name_len_in = name_len_ff;
      text_len_in = text_len_ff;
      remain_in   = remain_ff;
      ptr_hi_in   = ptr_hi_ff;
      err_in      = err_ff;
      grp_in      = grp_ff;
      cmd_pop     = 1'b0;
      mem_wr      = 1'b0;
      rd_en       = 1'b0;
      rd_pos      = pos_next;
      buf_wr      = 1'b0;
      buf_wdata   = rd_data_ff;
      buf_rd      = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               if (!cmd.decode) begin
                  mem_wr = cmd.in_range;
               end else begin
                  start_in    = cmd.offset;
                  limit_in    = cmd.limit;
                  pos_in      = POS_W'(cmd.offset);
                  hop_in      = '0;
                  jumped_in   = 1'b0;
                  wire_in     = '0;
                  name_len_in = '0;
                  text_len_in = '0;
                  grp_in      = '0;
                  err_in      = ERR_PAST_END;
                  rd_pos      = POS_W'(cmd.offset);
                  rd_en       = !start_past;
               end
            end
         end
         ST_HEAD: begin
            if (is_zero) begin
               if (!jumped_ff) begin
                  wire_in = 9'(span + 1'b1);
               end
            end else if (is_ptr) begin
               if (past_next) begin
                  err_in = ERR_PAST_END;
               end else if (hop_full) begin
                  err_in = ERR_HOPS;
               end else begin
                  hop_in    = hop_ff + 1'b1;
                  ptr_hi_in = rd_data_ff[5:0];
                  if (!jumped_ff) begin
                     wire_in   = 9'(span + 2'd2);
                     jumped_in = 1'b1;
                  end
                  rd_en  = 1'b1;
                  pos_in = pos_next;
               end
            end else if (!is_plain) begin
               err_in = ERR_RESERVED;
            end else if (long_name) begin
               err_in = ERR_TOO_LONG;
            end else begin
               name_len_in = name_len_ff + rd_data_ff + 1'b1;
               remain_in   = rd_data_ff[5:0];
               // dot between labels
               if (text_len_ff != '0) begin
                  buf_wr      = 1'b1;
                  buf_wdata   = CHAR_DOT;
                  text_len_in = text_len_ff + 1'b1;
               end
               if (past_next) begin
                  err_in = ERR_PAST_END;
               end else begin
                  rd_en  = 1'b1;
                  pos_in = pos_next;
               end
            end
         end
         ST_PTR: begin
            if (ptr_past) begin
               err_in = ERR_PAST_END;
            end else begin
               rd_en  = 1'b1;
               rd_pos = ptr_target;
               pos_in = ptr_target;
            end
         end
         ST_LABEL: begin
            buf_wr      = 1'b1;
            text_len_in = text_len_ff + 1'b1;
            remain_in   = remain_ff - 1'b1;
            if (past_next) begin
               err_in = ERR_PAST_END;
            end else begin
               rd_en  = 1'b1;
               pos_in = pos_next;
            end
         end
         ST_ERROR: begin
            grp_in = grp_ff;
         end
         ST_EMIT: begin
            if (can_issue) begin
               buf_rd = 1'b1;
               grp_in = grp_ff + 1'b1;
            end
         end
         default: begin
            grp_in = grp_ff;
         end
      endcase
   end

   // group read stage and output register control
   assign dv_in        = buf_rd | (dv_ff & !out_can_load);
   assign rsp_valid_in = load_grp | load_err | (rsp_valid_ff & !rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pos_ff       <= '0;
         start_ff     <= '0;
         limit_ff     <= '0;
         hop_ff       <= '0;
         jumped_ff    <= 1'b0;
         wire_ff      <= '0;
         name_len_ff  <= '0;
         text_len_ff  <= '0;
         remain_ff    <= '0;
         ptr_hi_ff    <= '0;
         err_ff       <= ERR_NONE;
         grp_ff       <= '0;
         dv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         start_ff     <= start_in;
         limit_ff     <= limit_in;
         hop_ff       <= hop_in;
         jumped_ff    <= jumped_in;
         wire_ff      <= wire_in;
         name_len_ff  <= name_len_in;
         text_len_ff  <= text_len_in;
         remain_ff    <= remain_in;
         ptr_hi_ff    <= ptr_hi_in;
         err_ff       <= err_in;
         grp_ff       <= grp_in;
         dv_ff        <= dv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // message store: one write or one read per cycle, registered read data
   always_ff @(posedge clock) begin
      if (mem_wr) begin
         msg_mem[AW'(cmd.offset)] <= cmd.data;
      end
      if (rd_en) begin
         rd_data_ff <= msg_mem[AW'(rd_pos)];
      end
   end

   // name buffer: character i goes to lane i mod 4, row i / 4
   always_ff @(posedge clock) begin
      for (int k = 0; k < LANES; k++) begin
         if (buf_wr && text_len_ff[1:0] == 2'(k)) begin
            name_buf[k][text_len_ff[TEXT_W-1:2]] <= buf_wdata;
         end
         if (buf_rd) begin
            grp_data_ff[k] <= name_buf[k][grp_ff];
         end
      end
   end

   // group metadata rides along with the buffer read
   always_ff @(posedge clock) begin
      if (buf_rd) begin
         cnt_pipe_ff  <= grp_cnt;
         last_pipe_ff <= (grp_ff == last_grp);
         wire_pipe_ff <= (grp_ff == last_grp) ? wire_ff : 9'd0;
      end
   end

   // output register: a group from the buffer or a lone error response
   always_ff @(posedge clock) begin
      if (load_grp) begin
         for (int k = 0; k < LANES; k++) begin
            rsp_char_ff[k] <= (3'(k) < cnt_pipe_ff) ? grp_data_ff[k] : 8'd0;
         end
         rsp_cnt_ff  <= cnt_pipe_ff;
         rsp_last_ff <= last_pipe_ff;
         rsp_wire_ff <= wire_pipe_ff;
         rsp_err_ff  <= ERR_NONE;
      end else if (load_err) begin
         for (int k = 0; k < LANES; k++) begin
            rsp_char_ff[k] <= 8'd0;
         end
         rsp_cnt_ff  <= 3'd0;
         rsp_last_ff <= 1'b1;
         rsp_wire_ff <= 9'd0;
         rsp_err_ff  <= err_ff;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.char_0      = rsp_char_ff[0];
   assign rsp_bus.char_1      = rsp_char_ff[1];
   assign rsp_bus.char_2      = rsp_char_ff[2];
   assign rsp_bus.char_3      = rsp_char_ff[3];
   assign rsp_bus.char_count  = rsp_cnt_ff;
   assign rsp_bus.last_group  = rsp_last_ff;
   assign rsp_bus.wire_length = rsp_wire_ff;
   assign rsp_bus.error_code  = rsp_err_ff;

endmodule

`default_nettype wire

>>> src/dns_name_decompressor.sv
// ---------------------------------------------------------------------------
// DNS name decompressor
// Loads message bytes, then expands compressed names into dotted text.
// ---------------------------------------------------------------------------
// A write request stores one message byte; a decode request walks the name
// at the given offset through the single read port of the message store,
// one store byte per cycle, reading each label head, each label character
// and both bytes of each compression pointer. The expanded name is then
// streamed as ceil(length / 4) responses (at least one), one per cycle while
// the consumer takes them. An error gives a single response, posted after
// the walk reaches the fault.
// A four-entry request queue lets requests arrive while the engine is busy.
// The message store has no reset; decoding bytes never written is undefined.
`timescale 1ns / 1ps
`default_nettype none

`include "dns_name_decompressor_macros.svh"

module dns_name_decompressor import dnd_pkg::*; #(
   parameter int MSG_BYTES = 512,
   parameter int MAX_NAME  = 255
) (
   input  logic              clock,
   input  logic              reset,
   dnd_req_if.sink           req_bus,
   dnd_rsp_if.source         rsp_bus,
   input  logic              csr_write_enable,
   input  logic [HOPS_W-1:0] csr_write_data
);

   logic [HOPS_W-1:0] max_hops_ff, max_hops_in;
   logic              cmd_valid;
   cmd_type           cmd;
   logic              cmd_pop;

   // hop limit register
   assign max_hops_in = csr_write_enable ? csr_write_data : max_hops_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_hops_ff <= HOPS_RESET;
      end else begin
         max_hops_ff <= max_hops_in;
      end
   end

   dnd_front #(
      .MSG_BYTES (MSG_BYTES)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop)
   );

   dnd_engine #(
      .MSG_BYTES (MSG_BYTES),
      .MAX_NAME  (MAX_NAME)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .max_hops  (max_hops_ff),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .rsp_bus   (rsp_bus)
   );

   // engine only pops a queued request
   `DND_ASSERT_SAME(a_pop_needs_item, clock, reset, cmd_pop, cmd_valid)
   // a decode keeps the engine busy for at least the next cycle
   `DND_ASSERT_NEXT(a_decode_busy, clock, reset, cmd_pop && cmd.decode, !cmd_pop)
   // only the final response carries a length or an error
   `DND_ASSERT_SAME(a_mid_group_clean, clock, reset, rsp_bus.valid && !rsp_bus.last_group,
                    rsp_bus.error_code == ERR_NONE && rsp_bus.wire_length == 9'd0)
   // an error response has no characters
   `DND_ASSERT_SAME(a_error_empty, clock, reset, rsp_bus.valid && rsp_bus.error_code != ERR_NONE,
                    rsp_bus.char_count == 3'd0 && rsp_bus.last_group)

endmodule

`default_nettype wire

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// DNS name decompressor testbench
// Loads message bytes and decodes names from them: plain labels, pointer
// chains, loops, reserved heads, truncated messages and the longest legal
// name. An in-bench name walker predicts every response group. Requests go
// out in random bursts and the consumer stalls on its own pattern, with one
// long hold-off that backs the block up.
// ---------------------------------------------------------------------------
module tb_top;
   import dnd_pkg::*;

   localparam int STORE_BYTES  = 512;
   localparam int NAME_LIMIT   = 255;
   localparam int CYCLE_LIMIT  = 2000000;
   localparam int DRAIN_CYCLES = 40;
   localparam int HOLD_CYCLES  = 300;
   localparam int RANDOM_ITEMS = 220;

   // label types the block must reject
   localparam logic [1:0] LBL_RESV_LO = 2'b01;
   localparam logic [1:0] LBL_RESV_HI = 2'b10;

   // fixed message layout used by the directed cases
   localparam int AT_LONGEST  = 0;    // 255-byte name, 253 characters
   localparam int AT_OVERLONG = 255;  // one label, then pointer to the longest
   localparam int AT_LOOP     = 259;  // pointer to itself
   localparam int AT_ROOT     = 261;
   localparam int AT_RESV_LO  = 262;
   localparam int AT_RESV_HI  = 263;
   localparam int AT_TO_ROOT  = 264;  // label, then pointer to the root
   localparam int AT_PLAIN    = 269;
   localparam int AT_HOP1     = 274;  // pointer to the plain name
   localparam int AT_HOP2     = 276;  // pointer to the one above
   localparam int AT_FAR      = 278;  // pointer far beyond any message
   localparam int LAYOUT_END  = 280;

   typedef struct packed {
      opcode_type op;
      logic [8:0] offset;
      logic [7:0] data;
      logic [9:0] msg_len;
   } name_req_t;

   typedef struct packed {
      logic [3:0][7:0] chars;
      logic [2:0]      count;
      logic            last;
      logic [8:0]      wire_len;
      logic [2:0]      err;
   } name_group_t;

   logic              clock      = 1'b0;
   logic              reset      = 1'b1;
   logic              csr_we     = 1'b0;
   logic [HOPS_W-1:0] csr_data   = HOPS_RESET;
   logic              drv_valid  = 1'b0;
   name_req_t         drv_req    = '0;
   logic              take_ready = 1'b0;

   dnd_req_if req_if ();
   dnd_rsp_if rsp_if ();

   assign req_if.valid          = drv_valid;
   assign req_if.opcode         = drv_req.op;
   assign req_if.byte_offset    = drv_req.offset;
   assign req_if.data_byte      = drv_req.data;
   assign req_if.message_length = drv_req.msg_len;
   assign rsp_if.ready          = take_ready;

   dns_name_decompressor DUT (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_if),
      .rsp_bus          (rsp_if),
      .csr_write_enable (csr_we),
      .csr_write_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // requests waiting to be sent, response groups waiting to arrive
   name_req_t   pending_reqs[$];
   name_group_t expected_groups[$];

   // store as planned by the generator, and as seen at acceptance
   logic [7:0] plan_bytes[STORE_BYTES];
   bit         plan_written[STORE_BYTES];
   logic [7:0] mirror_bytes[STORE_BYTES];

   logic [HOPS_W-1:0] hop_limit = HOPS_RESET;

   // expanded name of the last walk
   logic [7:0]  name_text[256];
   int unsigned text_len;
   bit          blank_read;

   int unsigned fail_count, group_count, decode_count, write_count, items_queued;
   int unsigned burst_left, gap_left, hold_left, stall_tick;
   bit          hold_armed, hold_done;

   function automatic logic [7:0] fetch_byte(bit from_plan, int unsigned addr);
      if (from_plan) begin
         if (!plan_written[addr])
            blank_read = 1'b1;
         return plan_bytes[addr];
      end
      return mirror_bytes[addr];
   endfunction

   // Walk the name at start; fills name_text and returns the error code.
   function automatic logic [2:0] expand_name(bit from_plan, logic [8:0] start,
                                              logic [9:0] msg_len,
                                              output logic [8:0] wire_len);
      int unsigned limit, pos, hops, wire_n, name_n, remain;
      logic [7:0]  head, c;
      bit          jumped;
      limit      = (msg_len < STORE_BYTES) ? msg_len : STORE_BYTES;
      pos        = start;
      hops       = 0;
      wire_n     = 0;
      name_n     = 0;
      jumped     = 1'b0;
      text_len   = 0;
      blank_read = 1'b0;
      wire_len   = '0;
      while (1'b1) begin
         if (pos >= limit)
            return ERR_PAST_END;
         head = fetch_byte(from_plan, pos);
         // terminating zero
         if (head == 8'd0) begin
            if (!jumped)
               wire_n = pos - start + 1;
            wire_len = wire_n[8:0];
            return ERR_NONE;
         end
         // compression pointer
         if (head[7:6] == LBL_POINTER) begin
            if (pos + 1 >= limit)
               return ERR_PAST_END;
            if (hops >= hop_limit)
               return ERR_HOPS;
            hops++;
            if (!jumped) begin
               wire_n = pos - start + 2;
               jumped = 1'b1;
            end
            pos = {head[5:0], fetch_byte(from_plan, pos + 1)};
         end else begin
            if (head[7:6] != LBL_PLAIN)
               return ERR_RESERVED;
            // length is checked before any character is read
            if (name_n + head + 2 > NAME_LIMIT)
               return ERR_TOO_LONG;
            if (text_len > 0 && text_len < 256) begin
               name_text[text_len] = CHAR_DOT;
               text_len++;
            end
            name_n += head + 1;
            pos++;
            for (remain = head; remain > 0; remain--) begin
               if (pos >= limit)
                  return ERR_PAST_END;
               c = fetch_byte(from_plan, pos);
               if (text_len < 256) begin
                  name_text[text_len] = c;
                  text_len++;
               end
               pos++;
            end
         end
      end
   endfunction

   // Apply an accepted request: update the store or queue the name groups.
   function automatic void record_request(name_req_t r);
      name_group_t g;
      logic [2:0]  err;
      logic [8:0]  wire_len;
      int unsigned groups, cnt;
      if (r.op == OP_WRITE) begin
         mirror_bytes[r.offset] = r.data;
         write_count++;
         return;
      end
      decode_count++;
      err = expand_name(1'b0, r.offset, r.msg_len, wire_len);
      if (err != ERR_NONE) begin
         g      = '0;
         g.last = 1'b1;
         g.err  = err;
         expected_groups.push_back(g);
         return;
      end
      groups = (text_len + 3) / 4;
      if (groups == 0)
         groups = 1;
      if (groups > 64)
         groups = 64;
      for (int unsigned n = 0; n < groups; n++) begin
         cnt = (text_len > 4 * n) ? text_len - 4 * n : 0;
         if (cnt > 4)
            cnt = 4;
         g = '0;
         for (int unsigned k = 0; k < 4; k++)
            g.chars[k] = (k < cnt) ? name_text[4 * n + k] : 8'd0;
         g.count    = 3'(cnt);
         g.last     = (n + 1 == groups);
         g.wire_len = g.last ? wire_len : 9'd0;
         g.err      = ERR_NONE;
         expected_groups.push_back(g);
      end
   endfunction

   function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
         fail_count++;
      end
   endfunction

   // ---------------------------------------------------------------------
   // Request generation
   // ---------------------------------------------------------------------
   function automatic void queue_write(int unsigned addr, logic [7:0] value);
      name_req_t r;
      r.op      = OP_WRITE;
      r.offset  = 9'(addr);
      r.data    = value;
      r.msg_len = 10'($urandom);
      pending_reqs.push_back(r);
      plan_bytes[addr]   = value;
      plan_written[addr] = 1'b1;
      items_queued++;
   endfunction

   // decodes that would read a never-written byte are dropped
   function automatic void queue_decode(int unsigned start, int unsigned msg_len);
      name_req_t  r;
      logic [8:0] wire_len;
      logic [2:0] err;
      err = expand_name(1'b1, 9'(start), 10'(msg_len), wire_len);
      if (blank_read)
         return;
      r.op      = OP_DECODE;
      r.offset  = 9'(start);
      r.data    = 8'($urandom);
      r.msg_len = 10'(msg_len);
      pending_reqs.push_back(r);
      items_queued++;
   endfunction

   function automatic void queue_label(inout int unsigned pos, input int unsigned len);
      queue_write(pos, 8'(len));
      pos++;
      repeat (len) begin
         queue_write(pos, 8'($urandom));
         pos++;
      end
   endfunction

   function automatic void queue_pointer(inout int unsigned pos, input logic [13:0] target);
      queue_write(pos, {LBL_POINTER, target[13:8]});
      queue_write(pos + 1, target[7:0]);
      pos += 2;
   endfunction

   function automatic int unsigned pick_msg_length(int unsigned lo, int unsigned hi);
      case ($urandom_range(0, 7))
         0:       return $urandom_range(lo, hi);
         1:       return $urandom_range(512, 1023);
         2:       return $urandom_range(0, 1023);
         default: return hi;
      endcase
   endfunction

   // One small message: a few names, some compressed against earlier ones,
   // then decodes at the name starts and at random offsets inside it.
   function automatic void random_round();
      int unsigned base, pos, len, pick, msg_end;
      int unsigned starts[$];
      bit          long_used;
      base      = $urandom_range(0, 370);
      pos       = base;
      long_used = 1'b0;
      repeat ($urandom_range(1, 3)) begin
         starts.push_back(pos);
         repeat ($urandom_range(0, 3)) begin
            if (!long_used && $urandom_range(0, 9) == 0) begin
               len       = $urandom_range(20, 63);
               long_used = 1'b1;
            end else
               len = $urandom_range(1, 6);
            queue_label(pos, len);
         end
         pick = $urandom_range(0, 15);
         if (pick < 8) begin
            queue_write(pos, 8'd0);
            pos++;
         end else if (pick < 12)
            queue_pointer(pos, 14'(starts[$urandom_range(0, starts.size() - 1)]));
         else if (pick < 14)
            queue_pointer(pos, 14'($urandom));
         else begin
            queue_write(pos, {(pick == 14) ? LBL_RESV_LO : LBL_RESV_HI, 6'($urandom)});
            pos++;
         end
      end
      msg_end = pos;
      foreach (starts[i]) begin
         queue_decode(starts[i], pick_msg_length(base, msg_end));
         queue_decode(starts[i], msg_end);
      end
      repeat ($urandom_range(1, 3))
         queue_decode($urandom_range(base, msg_end - 1), pick_msg_length(base, msg_end));
   endfunction

   // Register writes only once the block has gone quiet.
   task automatic set_hop_limit(logic [HOPS_W-1:0] value);
      while (pending_reqs.size() != 0 || expected_groups.size() != 0 || drv_valid)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_data <= value;
      csr_we   <= 1'b1;
      @(posedge clock);
      csr_we    <= 1'b0;
      hop_limit  = value;
      @(negedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Request driver: bursts of random length, random gaps
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : drive_requests
      bit offer;
      if (reset) begin
         drv_valid  <= 1'b0;
         burst_left  = 0;
         gap_left    = 0;
      end else begin
         if (drv_valid && req_if.ready) begin
            record_request(pending_reqs.pop_front());
            if (burst_left > 0)
               burst_left--;
         end
         // an offered request stays up until it is taken
         if (drv_valid && !req_if.ready)
            offer = 1'b1;
         else begin
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 16);
               gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            end
            if (gap_left > 0) begin
               gap_left--;
               offer = 1'b0;
            end else
               offer = (pending_reqs.size() != 0);
         end
         drv_valid <= offer;
         if (offer)
            drv_req <= pending_reqs[0];
      end
   end

   // ---------------------------------------------------------------------
   // Response monitor and consumer stall pattern
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : collect_groups
      name_group_t got, want;
      bit          ready_next;
      if (reset)
         take_ready <= 1'b0;
      else begin
         if (rsp_if.valid && take_ready) begin
            got.chars    = {rsp_if.char_3, rsp_if.char_2, rsp_if.char_1, rsp_if.char_0};
            got.count    = rsp_if.char_count;
            got.last     = rsp_if.last_group;
            got.wire_len = rsp_if.wire_length;
            got.err      = rsp_if.error_code;
            if (expected_groups.size() == 0) begin
               $error("name group arrived with no decode outstanding");
               fail_count++;
            end else begin
               want = expected_groups.pop_front();
               group_count++;
               check_field("char_0", want.chars[0], got.chars[0]);
               check_field("char_1", want.chars[1], got.chars[1]);
               check_field("char_2", want.chars[2], got.chars[2]);
               check_field("char_3", want.chars[3], got.chars[3]);
               check_field("char_count", want.count, got.count);
               check_field("last_group", want.last, got.last);
               check_field("wire_length", want.wire_len, got.wire_len);
               check_field("error_code", want.err, got.err);
            end
         end
         // one long hold-off, otherwise rotate through stall modes
         if (hold_left > 0) begin
            hold_left--;
            ready_next = 1'b0;
         end else if (hold_armed && !hold_done) begin
            hold_done  = 1'b1;
            hold_left  = HOLD_CYCLES;
            ready_next = 1'b0;
         end else begin
            stall_tick++;
            case ((stall_tick / 97) % 4)
               0:       ready_next = 1'b1;
               1:       ready_next = $urandom_range(0, 1);
               2:       ready_next = (stall_tick % 4) == 0;
               default: ready_next = $urandom_range(0, 7) != 0;
            endcase
         end
         take_ready <= ready_next;
      end
   end

   // run limit
   initial begin : watchdog
      int unsigned cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("FAILURE");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------
   initial begin : run_test
      int unsigned       pos, phase_start;
      logic [HOPS_W-1:0] phase_hops[4];
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      set_hop_limit(HOPS_RESET);

      // fixed layout
      pos = AT_LONGEST;
      repeat (3) queue_label(pos, 63);
      queue_label(pos, 61);
      queue_write(pos, 8'd0);
      pos++;
      queue_label(pos, 1);
      queue_pointer(pos, 14'(AT_LONGEST));
      queue_pointer(pos, 14'(AT_LOOP));
      queue_write(pos, 8'd0);
      queue_write(AT_RESV_LO, {LBL_RESV_LO, 6'($urandom)});
      queue_write(AT_RESV_HI, {LBL_RESV_HI, 6'($urandom)});
      pos = AT_TO_ROOT;
      queue_label(pos, 2);
      queue_pointer(pos, 14'(AT_ROOT));
      queue_label(pos, 3);
      queue_write(pos, 8'd0);
      pos++;
      queue_pointer(pos, 14'(AT_PLAIN));
      queue_pointer(pos, 14'(AT_HOP1));
      queue_pointer(pos, 14'h3FFF);

      // longest name, truncated message lengths, every error kind
      queue_decode(AT_LONGEST, STORE_BYTES);
      queue_decode(AT_LONGEST, 1023);
      queue_decode(AT_LONGEST, 254);
      queue_decode(AT_LONGEST, 100);
      queue_decode(AT_OVERLONG, STORE_BYTES);
      queue_decode(AT_LOOP, LAYOUT_END);
      queue_decode(AT_ROOT, LAYOUT_END);
      queue_decode(AT_ROOT, 0);
      queue_decode(AT_RESV_LO, LAYOUT_END);
      queue_decode(AT_RESV_HI, LAYOUT_END);
      queue_decode(AT_TO_ROOT, LAYOUT_END);
      queue_decode(AT_PLAIN, LAYOUT_END);
      queue_decode(AT_HOP1, LAYOUT_END);
      queue_decode(AT_HOP2, LAYOUT_END);
      queue_decode(AT_FAR, LAYOUT_END);
      queue_decode(AT_FAR, AT_FAR + 1);

      // hop limit extremes
      set_hop_limit(4'd1);
      queue_decode(AT_HOP1, LAYOUT_END);
      queue_decode(AT_HOP2, LAYOUT_END);
      set_hop_limit(4'd0);
      queue_decode(AT_HOP1, LAYOUT_END);
      queue_decode(AT_PLAIN, LAYOUT_END);
      set_hop_limit(4'd15);
      queue_decode(AT_LOOP, LAYOUT_END);
      queue_decode(AT_OVERLONG, STORE_BYTES);

      // random messages under several hop limits
      phase_hops[0] = 4'd15;
      phase_hops[1] = 4'd1;
      phase_hops[2] = 4'($urandom_range(2, 14));
      phase_hops[3] = HOPS_RESET;
      foreach (phase_hops[p]) begin
         set_hop_limit(phase_hops[p]);
         if (p == 0)
            hold_armed = 1'b1;
         phase_start = items_queued;
         while (items_queued - phase_start < RANDOM_ITEMS / 4)
            random_round();
      end

      while (pending_reqs.size() != 0 || expected_groups.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d requests: %0d byte writes and %0d decodes; %0d name groups checked.",
               write_count + decode_count, write_count, decode_count, group_count);
      $display("Hop limits 0, 1, 8 and 15 used; consumer held off once for %0d cycles.",
               HOLD_CYCLES);
      if (fail_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
